// ----- rtl/br1enc_pkg.sv -----
// shared types and constants for the byterun1 row encoder
package br1enc_pkg;

    localparam int MAX_GROUP        = 128;
    localparam int BYTES_PER_RESULT = 8;
    localparam int OUT_BYTES        = 8;
    localparam int OUT_IW           = $clog2(OUT_BYTES);
    localparam int CNT_W            = 4;
    localparam int GRP_W            = $clog2(MAX_GROUP + 1);
    localparam int RING_DEPTH       = 2 * MAX_GROUP;
    localparam int RING_AW          = $clog2(RING_DEPTH);
    localparam int RING_PW          = RING_AW + 1;
    localparam int CMD_DEPTH        = 4;
    localparam int CMD_AW           = $clog2(CMD_DEPTH);
    localparam int OUT_TDATA_W      = ((OUT_BYTES * 8 + CNT_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        CMD_LIT = 2'd0,
        CMD_RUN = 2'd1,
        CMD_END = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [GRP_W-1:0] len;
        logic [7:0]       value;
    } t_cmd;

    typedef struct packed {
        logic               we;
        logic [RING_AW-1:0] addr;
        logic [7:0]         data;
    } t_lit_wr;

    typedef struct packed {
        logic               re;
        logic [RING_AW-1:0] addr;
    } t_lit_rd;

    typedef struct packed {
        logic [OUT_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      last;
    } t_result;

    typedef enum logic [1:0] {
        F_IDLE = 2'd0,
        F_STEP = 2'd1,
        F_DONE = 2'd2
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE = 3'd0,
        B_HDR  = 3'd1,
        B_LIT  = 3'd2,
        B_RUNV = 3'd3,
        B_END  = 3'd4
    } t_back_state;

endpackage

// ----- rtl/br1enc_ram.sv -----
// generic simple dual-port ram with registered read
module br1enc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/br1enc_cmd_fifo.sv -----
// command queue between the classifier and the byte emitter
module br1enc_cmd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  br1enc_pkg::t_cmd  i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output br1enc_pkg::t_cmd  o_cmd,
    output logic              o_empty
);
    import br1enc_pkg::*;

    t_cmd            r_mem [0:CMD_DEPTH-1];
    logic [CMD_AW:0] r_wr;
    logic [CMD_AW:0] r_rd;
    logic [CMD_AW:0] n_wr;
    logic [CMD_AW:0] n_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = ((r_wr - r_rd) == (CMD_AW + 1)'(CMD_DEPTH));
    assign o_cmd   = r_mem[r_rd[CMD_AW-1:0]];

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_push && !o_full) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_pop && !o_empty) begin
            n_rd = r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr[CMD_AW-1:0]] <= i_cmd;
        end
    end

endmodule

// ----- rtl/br1enc_front.sv -----
// classifier: four-byte window, run detection and literal buffering
module br1enc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_data,
    input  logic                           i_row_end,
    output logic                           o_push,
    output br1enc_pkg::t_cmd               o_cmd,
    input  logic                           i_full,
    output br1enc_pkg::t_lit_wr            o_lit_wr,
    input  logic [br1enc_pkg::RING_PW-1:0] i_rd_ptr
);
    import br1enc_pkg::*;

    t_front_state       r_state, n_state;
    logic [7:0]         r_w [0:3];
    logic [7:0]         n_w [0:3];
    logic [2:0]         r_wn, n_wn;
    logic               r_end, n_end;
    logic               r_in_run, n_in_run;
    logic [7:0]         r_run_val, n_run_val;
    logic [GRP_W-1:0]   r_run_len, n_run_len;
    logic [GRP_W-1:0]   r_lit_cnt, n_lit_cnt;
    logic [RING_PW-1:0] r_wr_ptr, n_wr_ptr;

    logic [RING_PW-1:0] occ;
    logic               ring_full;
    logic               run_cond;
    logic               do_add;
    logic               do_pop;
    t_cmd               cmd;

    assign occ       = r_wr_ptr - i_rd_ptr;
    assign ring_full = (occ == RING_PW'(RING_DEPTH));
    assign run_cond  = (r_w[1] == r_w[0]) && ((r_w[2] == r_w[0]) || (r_w[2] == r_w[3]));
    assign o_ready   = (r_state == F_IDLE);
    assign o_cmd     = cmd;

    always_comb begin
        n_state   = r_state;
        n_w       = r_w;
        n_wn      = r_wn;
        n_end     = r_end;
        n_in_run  = r_in_run;
        n_run_val = r_run_val;
        n_run_len = r_run_len;
        n_lit_cnt = r_lit_cnt;
        n_wr_ptr  = r_wr_ptr;
        o_push    = 1'b0;
        cmd       = '{kind: CMD_END, len: '0, value: '0};
        o_lit_wr  = '{we: 1'b0, addr: r_wr_ptr[RING_AW-1:0], data: r_w[0]};
        do_add    = 1'b0;
        do_pop    = 1'b0;

        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_w[r_wn[1:0]] = i_data;
                    n_wn           = r_wn + 3'd1;
                    n_end          = i_row_end;
                    n_state        = F_STEP;
                end
            end
            F_STEP: begin
                if (!i_full && !ring_full) begin
                    if (r_in_run) begin
                        if (r_wn != 3'd0) begin
                            if (r_w[0] == r_run_val && r_run_len < GRP_W'(MAX_GROUP)) begin
                                n_run_len = r_run_len + 1'b1;
                                do_pop    = 1'b1;
                            end else begin
                                o_push   = 1'b1;
                                cmd      = '{kind: CMD_RUN, len: r_run_len, value: r_run_val};
                                n_in_run = 1'b0;
                            end
                        end else begin
                            if (r_end) begin
                                o_push   = 1'b1;
                                cmd      = '{kind: CMD_RUN, len: r_run_len, value: r_run_val};
                                n_in_run = 1'b0;
                            end
                            n_state = F_DONE;
                        end
                    end else if (r_wn == 3'd4) begin
                        if (run_cond) begin
                            if (r_lit_cnt != '0) begin
                                o_push = 1'b1;
                                cmd    = '{kind: CMD_LIT, len: r_lit_cnt, value: '0};
                            end
                            n_lit_cnt = '0;
                            n_run_val = r_w[0];
                            n_run_len = '0;
                            n_in_run  = 1'b1;
                        end else begin
                            do_add = 1'b1;
                        end
                    end else if (r_end && r_wn != 3'd0) begin
                        // short tail at row end goes into the literal group
                        do_add = 1'b1;
                    end else begin
                        if (r_end) begin
                            if (r_lit_cnt != '0) begin
                                o_push = 1'b1;
                                cmd    = '{kind: CMD_LIT, len: r_lit_cnt, value: '0};
                            end
                            n_lit_cnt = '0;
                        end
                        n_state = F_DONE;
                    end
                end
            end
            F_DONE: begin
                if (!i_full) begin
                    // end marker closes the results of this transaction
                    o_push  = 1'b1;
                    cmd     = '{kind: CMD_END, len: '0, value: '0};
                    n_end   = 1'b0;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase

        if (do_add) begin
            o_lit_wr.we = 1'b1;
            n_wr_ptr    = r_wr_ptr + 1'b1;
            do_pop      = 1'b1;
            if (r_lit_cnt == GRP_W'(MAX_GROUP - 1)) begin
                o_push    = 1'b1;
                cmd       = '{kind: CMD_LIT, len: GRP_W'(MAX_GROUP), value: '0};
                n_lit_cnt = '0;
            end else begin
                n_lit_cnt = r_lit_cnt + 1'b1;
            end
        end

        if (do_pop) begin
            n_w[0] = r_w[1];
            n_w[1] = r_w[2];
            n_w[2] = r_w[3];
            n_wn   = r_wn - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_wn      <= '0;
            r_end     <= 1'b0;
            r_in_run  <= 1'b0;
            r_run_len <= '0;
            r_lit_cnt <= '0;
            r_wr_ptr  <= '0;
        end else begin
            r_state   <= n_state;
            r_wn      <= n_wn;
            r_end     <= n_end;
            r_in_run  <= n_in_run;
            r_run_len <= n_run_len;
            r_lit_cnt <= n_lit_cnt;
            r_wr_ptr  <= n_wr_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w       <= n_w;
        r_run_val <= n_run_val;
    end

endmodule

// ----- rtl/br1enc_back.sv -----
// byte emitter: expands commands into coded bytes and packs them into results
module br1enc_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  br1enc_pkg::t_cmd               i_cmd,
    output logic                           o_pop,
    output br1enc_pkg::t_lit_rd            o_lit_rd,
    input  logic [7:0]                     i_rdata,
    output logic [br1enc_pkg::RING_PW-1:0] o_rd_ptr,
    output logic                           o_valid,
    input  logic                           i_ready,
    output br1enc_pkg::t_result            o_result
);
    import br1enc_pkg::*;

    t_back_state        r_state, n_state;
    t_cmd_kind          r_kind, n_kind;
    logic [GRP_W-1:0]   r_len, n_len;
    logic [7:0]         r_val, n_val;
    logic [GRP_W-1:0]   r_rem, n_rem;
    logic [RING_PW-1:0] r_rd_ptr, n_rd_ptr;

    logic [7:0]         r_acc [0:OUT_BYTES-1];
    logic [7:0]         n_acc [0:OUT_BYTES-1];
    logic [CNT_W-1:0]   r_acc_cnt, n_acc_cnt;
    logic               r_out_valid, n_out_valid;
    t_result            r_out;
    t_result            masked;

    logic [7:0]         hdr;
    logic               b_valid;
    logic               b_end;
    logic [7:0]         b_byte;
    logic               b_move;
    logic               b_ready;
    logic               load;
    logic               load_last;

    assign hdr = (r_kind == CMD_LIT) ? (8'(r_len) - 8'd1) : (8'd1 - 8'(r_len));

    // byte stream toward the packer, from state alone
    always_comb begin
        b_valid = 1'b0;
        b_end   = 1'b0;
        b_byte  = hdr;
        unique case (r_state)
            B_IDLE: begin
                b_valid = 1'b0;
            end
            B_HDR: begin
                b_valid = 1'b1;
            end
            B_LIT: begin
                b_valid = 1'b1;
                b_byte  = i_rdata;
            end
            B_RUNV: begin
                b_valid = 1'b1;
                b_byte  = r_val;
            end
            B_END: begin
                b_valid = 1'b1;
                b_end   = 1'b1;
            end
            default: begin
                b_valid = 1'b0;
            end
        endcase
    end

    // a full accumulator is only released once the next byte or the end marker shows up
    assign b_move  = b_valid && (b_end ? (r_acc_cnt != '0)
                                       : (r_acc_cnt == CNT_W'(BYTES_PER_RESULT)));
    assign b_ready = !b_move || !r_out_valid || i_ready;

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_len    = r_len;
        n_val    = r_val;
        n_rem    = r_rem;
        n_rd_ptr = r_rd_ptr;
        o_pop    = 1'b0;
        o_lit_rd = '{re: 1'b0, addr: r_rd_ptr[RING_AW-1:0]};

        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_kind  = i_cmd.kind;
                    n_len   = i_cmd.len;
                    n_val   = i_cmd.value;
                    n_state = (i_cmd.kind == CMD_END) ? B_END : B_HDR;
                end
            end
            B_HDR: begin
                if (b_ready) begin
                    if (r_kind == CMD_LIT) begin
                        o_lit_rd.re = 1'b1;
                        n_rd_ptr    = r_rd_ptr + 1'b1;
                        n_rem       = r_len;
                        n_state     = B_LIT;
                    end else begin
                        n_state = B_RUNV;
                    end
                end
            end
            B_LIT: begin
                // ram output holds while the packer stalls
                if (b_ready) begin
                    if (r_rem > GRP_W'(1)) begin
                        o_lit_rd.re = 1'b1;
                        n_rd_ptr    = r_rd_ptr + 1'b1;
                        n_rem       = r_rem - 1'b1;
                    end else begin
                        n_state = B_IDLE;
                    end
                end
            end
            B_RUNV: begin
                if (b_ready) begin
                    n_state = B_IDLE;
                end
            end
            B_END: begin
                if (b_ready) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_comb begin
        n_acc     = r_acc;
        n_acc_cnt = r_acc_cnt;
        load      = 1'b0;
        load_last = 1'b0;
        if (b_valid && b_ready) begin
            if (b_end) begin
                if (r_acc_cnt != '0) begin
                    load      = 1'b1;
                    load_last = 1'b1;
                end
                n_acc_cnt = '0;
            end else if (r_acc_cnt == CNT_W'(BYTES_PER_RESULT)) begin
                load      = 1'b1;
                n_acc[0]  = b_byte;
                n_acc_cnt = CNT_W'(1);
            end else begin
                n_acc[r_acc_cnt[OUT_IW-1:0]] = b_byte;
                n_acc_cnt                    = r_acc_cnt + 1'b1;
            end
        end
        n_out_valid = load || (r_out_valid && !i_ready);
    end

    always_comb begin
        for (int j = 0; j < OUT_BYTES; j++) begin
            masked.bytes[j] = (CNT_W'(j) < r_acc_cnt) ? r_acc[j] : 8'd0;
        end
        masked.count = r_acc_cnt;
        masked.last  = load_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_rd_ptr    <= '0;
            r_acc_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_ptr    <= n_rd_ptr;
            r_acc_cnt   <= n_acc_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_len  <= n_len;
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_acc  <= n_acc;
        if (load) begin
            r_out <= masked;
        end
    end

    assign o_rd_ptr = r_rd_ptr;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ----- rtl/byterun1_row_encoder_unit.sv -----
// top level of the byterun1 (packbits) row encoder
// Usage: raw row bytes enter on the s_axis channel, one byte per transaction,
// with tlast on the final byte of a row. Coded bytes leave on the m_axis
// channel packed up to eight per transaction: tdata carries the bytes and
// their count, tlast marks the final result caused by one input transaction.
// An input that decides no coded byte gives no result at all.
// The front classifier works one window action per cycle while the command queue
// and literal buffer have room. An input byte is accepted, then classified by one
// window action after another, also when a run starts and breaks inside one window
// and a row end flushes the rest, then closed by an end marker; s_axis_tready is
// high again after that. The back emitter takes a command in its idle state and
// then emits each coded byte in turn, stopping while the packer stalls: header and
// value for a run, header and bytes for a literal group, with literal bytes read
// through the registered ram port. Once its end marker is queued, a result passes
// the idle and end states of the emitter, then the output register.
// Reset (synchronous, active low) empties the window, the command queue and the
// literal buffer pointers; no clearing pass runs, the block is ready right after.
// When the receiver stalls, the output register holds its result, the emitter
// stops once its accumulator is full too, and the command queue (4 entries) and
// literal buffer (256 bytes) fill before the front stops taking input.
module byterun1_row_encoder_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [7:0]                         i_s_axis_tdata,  // data_byte
    input  logic                               i_s_axis_tlast,  // row_end
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // out_byte0..out_byte7 [63:0], byte_count [67:64], zero pad above
    output logic [br1enc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                               o_m_axis_tlast   // group_last
);
    import br1enc_pkg::*;

    logic               push;
    t_cmd               push_cmd;
    logic               full;
    logic               pop;
    t_cmd               head_cmd;
    logic               empty;
    t_lit_wr            lit_wr;
    t_lit_rd            lit_rd;
    logic [7:0]         lit_rdata;
    logic [RING_PW-1:0] rd_ptr;
    t_result            result;

    br1enc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_data    (i_s_axis_tdata),
        .i_row_end (i_s_axis_tlast),
        .o_push    (push),
        .o_cmd     (push_cmd),
        .i_full    (full),
        .o_lit_wr  (lit_wr),
        .i_rd_ptr  (rd_ptr)
    );

    br1enc_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    br1enc_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_lit_ram (
        .i_clk   (i_clk),
        .i_we    (lit_wr.we),
        .i_waddr (lit_wr.addr),
        .i_wdata (lit_wr.data),
        .i_re    (lit_rd.re),
        .i_raddr (lit_rd.addr),
        .o_rdata (lit_rdata)
    );

    br1enc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_cmd    (head_cmd),
        .o_pop    (pop),
        .o_lit_rd (lit_rd),
        .i_rdata  (lit_rdata),
        .o_rd_ptr (rd_ptr),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (result)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'({result.count, result.bytes});
    assign o_m_axis_tlast = result.last;

endmodule

// ----- dv/byterun1_row_encoder_unit_tb.sv -----
// self-checking testbench for the byterun1 row encoder: table, random rows, predictor
module byterun1_row_encoder_unit_tb;
    import br1enc_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 96;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        logic [7:0] data;
        logic       row_end;
        bit         typed;
        t_result    want;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [7:0]             i_s_axis_tdata = '0;
    logic                   i_s_axis_tlast = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;

    // row coder state
    logic [7:0] lit_buf [MAX_GROUP];
    int         lit_cnt = 0;
    logic [7:0] look [3] = '{default: '0};
    int         look_n = 0;
    logic [7:0] run_val = '0;
    int         run_len = 0;
    bit         running = 1'b0;
    logic [7:0] coded [$];
    t_result    coded_results [$];

    t_result    pending_results [$];
    int         errors = 0;
    int         idle_cycles = 0;

    bit         cur_typed = 1'b0;
    t_result    cur_want = '0;
    bit         src_calm = 1'b0;
    bit         sink_calm = 1'b1;
    int         sink_cnt = 0;
    int         stall = 0;
    int         stall_left = 0;
    t_result    got;
    t_result    want_r;

    t_stim_row  dir_tab [23];
    logic [7:0] row_q [$];
    int         rnd_items = 0;

    byterun1_row_encoder_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void flush_lits();
        if (lit_cnt == 0) return;
        coded.push_back(8'(lit_cnt - 1));
        for (int i = 0; i < lit_cnt; i++) coded.push_back(lit_buf[i]);
        lit_cnt = 0;
    endfunction

    function automatic void push_lit(input logic [7:0] b);
        if (lit_cnt >= MAX_GROUP) flush_lits();
        lit_buf[lit_cnt] = b;
        lit_cnt++;
        if (lit_cnt >= MAX_GROUP) flush_lits();
    endfunction

    function automatic void close_run();
        coded.push_back(8'(1 - run_len));
        coded.push_back(run_val);
        running = 1'b0;
        run_len = 0;
    endfunction

    // codes one row byte, leaves the packed results in coded_results
    function automatic void encode_byte(input logic [7:0] b, input logic row_end);
        logic [7:0] w [$];
        t_result    r;
        int         n;
        coded.delete();
        coded_results.delete();
        for (int i = 0; i < look_n; i++) w.push_back(look[i]);
        w.push_back(b);
        forever begin
            if (running) begin
                if (w.size() > 0) begin
                    if (w[0] == run_val && run_len < MAX_GROUP) begin
                        run_len++;
                        void'(w.pop_front());
                    end else begin
                        close_run();
                    end
                    continue;
                end
                if (row_end) close_run();
                break;
            end
            if (w.size() == 4) begin
                // run needs a pair plus either a third equal byte or a second pair
                if (w[1] == w[0] && (w[2] == w[0] || w[2] == w[3])) begin
                    flush_lits();
                    run_val = w[0];
                    run_len = 0;
                    running = 1'b1;
                end else begin
                    push_lit(w[0]);
                    void'(w.pop_front());
                end
                continue;
            end
            if (row_end) begin
                foreach (w[i]) push_lit(w[i]);
                w.delete();
                flush_lits();
            end
            break;
        end
        look_n = w.size();
        for (int i = 0; i < 3; i++) look[i] = (i < look_n) ? w[i] : 8'h00;
        for (int base = 0; base < coded.size(); base += BYTES_PER_RESULT) begin
            r = '0;
            n = coded.size() - base;
            if (n > BYTES_PER_RESULT) n = BYTES_PER_RESULT;
            for (int j = 0; j < n; j++) r.bytes[j] = coded[base + j];
            r.count = CNT_W'(n);
            r.last = (base + BYTES_PER_RESULT >= coded.size());
            coded_results.push_back(r);
        end
    endfunction

    function automatic t_stim_row plain(input logic [7:0] d, input logic e);
        t_stim_row s;
        s.data = d;
        s.row_end = e;
        s.typed = 1'b0;
        s.want = '0;
        return s;
    endfunction

    // final byte of a row whose whole coding is one short result
    function automatic t_stim_row known(input logic [7:0] d, input logic [7:0] b0, b1, b2, b3,
                                        input int cnt);
        t_stim_row s;
        s.data = d;
        s.row_end = 1'b1;
        s.typed = 1'b1;
        s.want = '0;
        s.want.bytes[0] = b0;
        s.want.bytes[1] = b1;
        s.want.bytes[2] = b2;
        s.want.bytes[3] = b3;
        s.want.count = CNT_W'(cnt);
        s.want.last = 1'b1;
        return s;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic e, input bit typed,
                             input t_result want);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= b;
        i_s_axis_tlast <= e;
        cur_typed <= typed;
        cur_want <= want;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic send_row();
        src_calm = ($urandom_range(0, 2) == 0);
        foreach (row_q[i]) send_byte(row_q[i], i == row_q.size() - 1, 1'b0, '0);
    endtask

    // input side prediction and output side checking, both at the clock edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                encode_byte(i_s_axis_tdata, i_s_axis_tlast);
                if (cur_typed) pending_results.push_back(cur_want);
                else foreach (coded_results[i]) pending_results.push_back(coded_results[i]);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.bytes = o_m_axis_tdata[OUT_BYTES*8-1:0];
                got.count = o_m_axis_tdata[OUT_BYTES*8 +: CNT_W];
                got.last = o_m_axis_tlast;
                if (pending_results.size() == 0) begin
                    $error("unexpected result transaction: tdata %h tlast %b",
                           o_m_axis_tdata, o_m_axis_tlast);
                    errors++;
                end else begin
                    want_r = pending_results.pop_front();
                    for (int j = 0; j < OUT_BYTES; j++) begin
                        if (got.bytes[j] !== want_r.bytes[j]) begin
                            $error("out_byte%0d: expected %h, got %h",
                                   j, want_r.bytes[j], got.bytes[j]);
                            errors++;
                        end
                    end
                    if (got.count !== want_r.count) begin
                        $error("byte_count: expected %0d, got %0d", want_r.count, got.count);
                        errors++;
                    end
                    if (got.last !== want_r.last) begin
                        $error("group_last: expected %b, got %b", want_r.last, got.last);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver stalls, with the calm or stalling mode redrawn every sixteen transactions
    always @(posedge i_clk) begin
        if (i_m_axis_tready && o_m_axis_tvalid) begin
            sink_cnt <= sink_cnt + 1;
            if (sink_cnt % 16 == 15) sink_calm <= ($urandom_range(0, 2) == 0);
            stall = sink_calm ? 0 : $urandom_range(0, 19);
            stall_left <= stall;
            i_m_axis_tready <= (stall == 0);
        end else if (!i_m_axis_tready) begin
            if (stall_left <= 1) i_m_axis_tready <= 1'b1;
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int nseg;
        int kind;
        int len;
        logic [7:0] v;

        dir_tab = '{
            known(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 2),
            known(8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 2),
            plain(8'hA5, 1'b0), plain(8'hA5, 1'b0), plain(8'hA5, 1'b0),
            known(8'hA5, 8'hFD, 8'hA5, 8'h00, 8'h00, 2),
            // short tail stays literal
            plain(8'h11, 1'b0), plain(8'h11, 1'b0),
            known(8'h11, 8'h02, 8'h11, 8'h11, 8'h11, 4),
            // two pairs start a run
            plain(8'h22, 1'b0), plain(8'h22, 1'b0), plain(8'h33, 1'b0), plain(8'h33, 1'b1),
            plain(8'h01, 1'b0), plain(8'h80, 1'b0), plain(8'h7F, 1'b0), plain(8'h80, 1'b0),
            plain(8'h80, 1'b0), plain(8'h7F, 1'b1),
            // three equal then a different byte
            plain(8'h5C, 1'b0), plain(8'h5C, 1'b0), plain(8'h5C, 1'b0), plain(8'h01, 1'b1)
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_calm = 1'b0;
        foreach (dir_tab[i]) begin
            send_byte(dir_tab[i].data, dir_tab[i].row_end, dir_tab[i].typed, dir_tab[i].want);
        end

        while (rnd_items < RANDOM_ITEMS) begin
            row_q.delete();
            nseg = $urandom_range(1, 4);
            for (int s = 0; s < nseg; s++) begin
                kind = $urandom_range(0, 9);
                if (kind < 5) begin
                    v = 8'($urandom);
                    len = $urandom_range(1, 7);
                    repeat (len) row_q.push_back(v);
                end else if (kind < 8) begin
                    // narrow alphabet gives pairs and near-runs
                    v = 8'($urandom);
                    len = $urandom_range(1, 6);
                    repeat (len) row_q.push_back(v ^ 8'($urandom_range(0, 3)));
                end else begin
                    len = $urandom_range(1, 5);
                    repeat (len) row_q.push_back(8'($urandom));
                end
            end
            rnd_items += row_q.size();
            send_row();
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/br1enc_pkg.sv
rtl/br1enc_ram.sv
rtl/br1enc_cmd_fifo.sv
rtl/br1enc_front.sv
rtl/br1enc_back.sv
rtl/byterun1_row_encoder_unit.sv
dv/byterun1_row_encoder_unit_tb.sv
